>>> design/nis_pkg.sv
// ----------------------------------------------------------------------------
// nis_pkg
// Shared types, codes and step-list helpers of the node interview sequencer.
// ----------------------------------------------------------------------------
package nis_pkg;

    // event codes
    localparam logic [1:0] OP_INCLUDED = 2'd0;
    localparam logic [1:0] OP_SECURITY = 2'd1;
    localparam logic [1:0] OP_REPORT   = 2'd2;

    // interview steps
    localparam logic [1:0] STEP_MFR       = 2'd0;
    localparam logic [1:0] STEP_VERSION   = 2'd1;
    localparam logic [1:0] STEP_ENDPOINTS = 2'd2;
    localparam logic [1:0] STEP_PLUS      = 2'd3;

    // result kinds
    localparam logic KIND_GET      = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    // one input event
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] node;
        logic       mc;
        logic       pi;
        logic       sec;
        logic [3:0] scheme;
        logic [1:0] rep;
    } item_t;

    // session entry, minus the valid bit (kept in flops)
    typedef struct packed {
        logic       started;
        logic [1:0] pos;
        logic       mc;
        logic       pi;
    } entry_t;

    // update computed for one event
    typedef struct packed {
        logic       we;
        logic       valid;
        entry_t     entry;
        logic       emit;
        logic       kind;
        logic [1:0] step;
    } upd_t;

    // number of steps in the plan: 2..4
    function automatic logic [2:0] plan_length(input entry_t e);
        plan_length = 3'd2 + {2'b00, e.mc} + {2'b00, e.pi};
    endfunction

    // step found at a plan position
    function automatic logic [1:0] step_at(input entry_t e, input logic [1:0] p);
        logic [1:0] s;
        unique case (p)
            2'd0: s = STEP_MFR;
            2'd1: s = STEP_VERSION;
            2'd2: s = e.mc ? STEP_ENDPOINTS : STEP_PLUS;
            default: s = STEP_PLUS;
        endcase
        step_at = s;
    endfunction

endpackage

>>> design/node_interview_sequencer.sv
// ----------------------------------------------------------------------------
// node_interview_sequencer
// Per-node interview sessions driven by inclusion, security and report events.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_*     | in  | node_id, has_multi_channel, has_plus_info,  | op
//          |     | has_security, security_scheme, report_step  |
//  m_*     | out | out_node, request_step                      | result_kind
//
//  One beat accepted per cycle unless a stalled output holds the stages; an
//  accepted beat passes through the stage one register, then the output register.
//  Stage one reads the session memory (registered read), stage two updates
//  the entry and loads the output register; a bypass covers same-node beats.
//  Reset clears the valid flops of all slots at once; no clearing pass.
//  A stalled output holds stage two, and stage one holds behind it.
// ----------------------------------------------------------------------------
module node_interview_sequencer
#(
    parameter int NODE_SLOTS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // node_id[7:0], has_multi_channel[8], has_plus_info[9],
                                   // has_security[10], security_scheme[14:11],
                                   // report_step[16:15], zero[23:17]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_node[7:0], request_step[9:8], zero[15:10]
    output logic        m_tuser    // result_kind
);

    localparam int SLOT_W = $clog2(NODE_SLOTS);

    nis_pkg::item_t  in_item;
    nis_pkg::item_t  s1_item_reg;
    logic            s1_valid_reg;
    nis_pkg::entry_t rd_reg;
    logic            byp_reg;
    nis_pkg::entry_t byp_data_reg;
    logic [NODE_SLOTS-1:0] valid_reg;
    nis_pkg::entry_t mem [NODE_SLOTS];

    logic            out_valid_reg;
    logic [7:0]      out_node_reg;
    logic            out_kind_reg;
    logic [1:0]      out_step_reg;

    logic            acc;
    logic            advance;
    logic            in_range;
    logic            mem_we;
    logic [SLOT_W-1:0] acc_idx;
    logic [SLOT_W-1:0] s1_idx;
    nis_pkg::entry_t cur;
    nis_pkg::upd_t   upd;

    // input unpack
    assign in_item.op     = s_tuser;
    assign in_item.node   = s_tdata[7:0];
    assign in_item.mc     = s_tdata[8];
    assign in_item.pi     = s_tdata[9];
    assign in_item.sec    = s_tdata[10];
    assign in_item.scheme = s_tdata[14:11];
    assign in_item.rep    = s_tdata[16:15];

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign acc      = s_tvalid && s_tready;

    assign acc_idx  = in_item.node[SLOT_W-1:0];
    assign s1_idx   = s1_item_reg.node[SLOT_W-1:0];
    assign in_range = ({1'b0, s1_item_reg.node} < 9'(NODE_SLOTS));
    assign mem_we   = s1_valid_reg && advance && in_range && upd.we;

    // current entry, forwarded when the previous beat wrote the same slot
    assign cur = byp_reg ? byp_data_reg : rd_reg;

    nis_step u_step
    (
        .item      (s1_item_reg),
        .cur_valid (valid_reg[s1_idx]),
        .cur       (cur),
        .upd       (upd)
    );

    // session memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[s1_idx] <= upd.entry;
        end
        if (acc)
        begin
            rd_reg <= mem[acc_idx];
        end
    end

    // stage one payload and bypass data
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_item_reg  <= in_item;
            byp_data_reg <= upd.entry;
        end
    end

    // control: stage valid, bypass flag, slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            if (acc)
            begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= mem_we && (s1_idx == acc_idx);
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
                byp_reg      <= 1'b0;
            end
            if (mem_we)
            begin
                valid_reg[s1_idx] <= upd.valid;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && in_range && upd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_node_reg <= s1_item_reg.node;
            out_kind_reg <= upd.kind;
            out_step_reg <= upd.step;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_step_reg, out_node_reg};
    assign m_tuser  = out_kind_reg;

    // checks
    a_complete_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == nis_pkg::KIND_COMPLETE)) |-> (m_tdata[9:8] == 2'd0))
        else $error("complete result carries nonzero step");

    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> s1_valid_reg)
        else $error("accepted beat lost from stage one");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("stage one changed while stalled");

    a_write_needs_advance: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (s1_valid_reg && advance))
        else $error("session write without a moving beat");

    a_bypass_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> s1_valid_reg)
        else $error("bypass armed with empty stage");

endmodule

>>> design/nis_step.sv
// ----------------------------------------------------------------------------
// nis_step
// Next-state and result logic for one event against one session entry.
// ----------------------------------------------------------------------------
module nis_step
(
    input  nis_pkg::item_t  item,
    input  logic            cur_valid,
    input  nis_pkg::entry_t cur,
    output nis_pkg::upd_t   upd
);

    logic [2:0] len;
    logic [2:0] next_pos;
    logic       match;

    // report bookkeeping
    assign len      = nis_pkg::plan_length(cur);
    assign next_pos = {1'b0, cur.pos} + 3'd1;
    assign match    = cur_valid && cur.started && ({1'b0, cur.pos} < len)
                      && (nis_pkg::step_at(cur, cur.pos) == item.rep);

    // event decode
    always_comb
    begin
        upd       = '0;
        upd.valid = cur_valid;
        upd.entry = cur;
        upd.kind  = nis_pkg::KIND_GET;
        upd.step  = nis_pkg::STEP_MFR;
        unique case (item.op)
            nis_pkg::OP_INCLUDED:
            begin
                upd.we            = 1'b1;
                upd.valid         = 1'b1;
                upd.entry.started = !item.sec;
                upd.entry.pos     = 2'd0;
                upd.entry.mc      = item.mc;
                upd.entry.pi      = item.pi;
                upd.emit          = !item.sec;
            end
            nis_pkg::OP_SECURITY:
            begin
                if ((item.scheme != 4'd0) && cur_valid && !cur.started)
                begin
                    upd.we            = 1'b1;
                    upd.entry.started = 1'b1;
                    upd.entry.pos     = 2'd0;
                    upd.emit          = 1'b1;
                end
            end
            nis_pkg::OP_REPORT:
            begin
                if (match)
                begin
                    upd.we   = 1'b1;
                    upd.emit = 1'b1;
                    if (next_pos >= len)
                    begin
                        // last step done: free the session
                        upd.valid = 1'b0;
                        upd.entry = '0;
                        upd.kind  = nis_pkg::KIND_COMPLETE;
                    end
                    else
                    begin
                        upd.entry.pos = next_pos[1:0];
                        upd.step      = nis_pkg::step_at(cur, next_pos[1:0]);
                    end
                end
            end
            default:
            begin
                // unused op: no effect
                upd.we = 1'b0;
            end
        endcase
    end

endmodule

>>> tb/tb_node_interview_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_node_interview_sequencer
// Self-checking bench for the node interview sequencer. A short table of
// directed beats walks reset, stray events, secure and non-secure interviews,
// reinclusion and ignored ops. A long random run follows, mostly well-formed
// interview traffic on a small pool of nodes, mixed with noise. Every accepted
// beat runs through a session-table predictor, and each result beat is
// compared in order against the predicted queue. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_node_interview_sequencer;

    localparam int         RANDOM_ITEMS    = 1825;
    localparam int         WATCHDOG_CYCLES = 1000;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         POOL_SIZE       = 6;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    // session entry kept by the predictor
    typedef struct packed {
        logic       valid;
        logic       started;
        logic [1:0] pos;
        logic       mc;
        logic       pi;
    } session_t;

    // one result beat
    typedef struct packed {
        logic [7:0] node;
        logic       kind;
        logic [1:0] step;
    } interview_result_t;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_SILENT,
        CHK_FIXED
    } check_mode_t;

    typedef struct {
        nis_pkg::item_t    it;
        check_mode_t       chk;
        interview_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // node_id, mc, pi, sec, scheme[3:0], report_step[1:0], zero
    logic [1:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // out_node, request_step[1:0], zero
    logic        m_tuser;   // result_kind

    session_t          sessions [256];
    logic [7:0]        node_pool [POOL_SIZE];
    interview_result_t pending_results [$];
    stim_row_t         dir_rows [$];
    interview_result_t want;
    int                errors    = 0;
    bit                rx_burst  = 1'b0;
    bit                tx_burst  = 1'b0;

    node_interview_sequencer u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // number of steps in a session's plan
    function automatic int plan_len(input session_t s);
        return 2 + int'(s.mc) + int'(s.pi);
    endfunction

    // step awaited at a plan position
    function automatic logic [1:0] plan_step(input session_t s, input logic [1:0] p);
        case (p)
            2'd0:    return nis_pkg::STEP_MFR;
            2'd1:    return nis_pkg::STEP_VERSION;
            2'd2:    return s.mc ? nis_pkg::STEP_ENDPOINTS : nis_pkg::STEP_PLUS;
            default: return nis_pkg::STEP_PLUS;
        endcase
    endfunction

    // apply one event to the session table; returns 1 when a result follows
    function automatic bit advance_interview(input nis_pkg::item_t it,
                                             output interview_result_t r);
        session_t s;
        bit       fires;
        s      = sessions[it.node];
        fires  = 1'b0;
        r.node = it.node;
        r.kind = nis_pkg::KIND_GET;
        r.step = nis_pkg::STEP_MFR;
        case (it.op)
            nis_pkg::OP_INCLUDED:
            begin
                s.valid   = 1'b1;
                s.mc      = it.mc;
                s.pi      = it.pi;
                s.pos     = 2'd0;
                s.started = !it.sec;
                fires     = !it.sec;
            end
            nis_pkg::OP_SECURITY:
            begin
                if (it.scheme != 4'd0 && s.valid && !s.started)
                begin
                    s.started = 1'b1;
                    s.pos     = 2'd0;
                    fires     = 1'b1;
                end
            end
            nis_pkg::OP_REPORT:
            begin
                if (s.valid && s.started && int'(s.pos) < plan_len(s)
                    && plan_step(s, s.pos) == it.rep)
                begin
                    fires = 1'b1;
                    if (int'(s.pos) + 1 >= plan_len(s))
                    begin
                        // last step done: free the entry, step field reads zero
                        s      = '0;
                        r.kind = nis_pkg::KIND_COMPLETE;
                        r.step = '0;
                    end
                    else
                    begin
                        s.pos  = s.pos + 2'd1;
                        r.step = plan_step(s, s.pos);
                    end
                end
            end
            default: ;
        endcase
        sessions[it.node] = s;
        return fires;
    endfunction

    // directed row builder
    function automatic stim_row_t mk_row(input logic [1:0] op, input logic [7:0] node,
                                         input logic mc, input logic pi, input logic sec,
                                         input logic [3:0] scheme, input logic [1:0] rep,
                                         input check_mode_t chk, input logic kind,
                                         input logic [1:0] step);
        stim_row_t row;
        row.it.op     = op;
        row.it.node   = node;
        row.it.mc     = mc;
        row.it.pi     = pi;
        row.it.sec    = sec;
        row.it.scheme = scheme;
        row.it.rep    = rep;
        row.chk       = chk;
        row.res.node  = node;
        row.res.kind  = kind;
        row.res.step  = step;
        return row;
    endfunction

    // append one directed row
    function automatic void add_row(input stim_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // append one expected result beat
    function automatic void queue_result(input interview_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // random event: mostly the next well-formed step of a pool node, else noise
    function automatic nis_pkg::item_t random_event();
        nis_pkg::item_t it;
        session_t       s;
        it.op     = 2'($urandom_range(0, 3));
        it.node   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : node_pool[$urandom_range(0, POOL_SIZE - 1)];
        it.mc     = 1'($urandom_range(0, 1));
        it.pi     = 1'($urandom_range(0, 1));
        it.sec    = 1'($urandom_range(0, 1));
        it.scheme = 4'($urandom_range(0, 15));
        it.rep    = 2'($urandom_range(0, 3));
        s         = sessions[it.node];
        if ($urandom_range(0, 9) < 7)
        begin
            if (!s.valid || $urandom_range(0, 19) == 0)
            begin
                it.op  = nis_pkg::OP_INCLUDED;
                it.sec = ($urandom_range(0, 2) == 0);
            end
            else if (!s.started)
            begin
                it.op     = nis_pkg::OP_SECURITY;
                it.scheme = 4'($urandom_range(1, 15));
            end
            else
            begin
                it.op  = nis_pkg::OP_REPORT;
                it.rep = plan_step(s, s.pos);
            end
        end
        return it;
    endfunction

    // drive one input beat after a random gap, then predict on acceptance
    task automatic send_beat(input nis_pkg::item_t it, input check_mode_t chk,
                             input interview_result_t fixed, output bit fires);
        int                gap;
        interview_result_t r;
        gap = tx_burst ? 0 : $urandom_range(0, 16);
        if ($urandom_range(0, 49) == 0)
            tx_burst = !tx_burst;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tdata  = {7'd0, it.rep, it.scheme, it.sec, it.pi, it.mc, it.node};
        s_tuser  = it.op;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        fires = advance_interview(it, r);
        case (chk)
            CHK_MODEL:  if (fires) queue_result(r);
            CHK_FIXED:  queue_result(fixed);
            default:    ;
        endcase
    endtask

    // stop sending and wait for every pending result
    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // result side ready, with a random stall after each result beat
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            gap = rx_burst ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            if (gap > 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display(
                    "%0t: unexpected result: expected none, actual node %0d kind %0d step %0d",
                    $time, m_tdata[7:0], m_tuser, m_tdata[9:8]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.node != m_tdata[7:0] || want.kind != m_tuser
                    || want.step != m_tdata[9:8])
                begin
                    errors++;
                    $display(
                        "%0t: mismatch: expected node/kind/step %0d/%0d/%0d, actual %0d/%0d/%0d",
                        $time, want.node, want.kind, want.step,
                        m_tdata[7:0], m_tuser, m_tdata[9:8]);
                end
            end
        end
    end

    // watchdog: too long without any beat on either side
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_CYCLES)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        bit                fires;
        nis_pkg::item_t    it;
        interview_result_t no_fixed;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        no_fixed = '0;
        for (int i = 0; i < 256; i++)
            sessions[i] = '0;
        node_pool[0] = 8'd0;
        node_pool[1] = 8'd255;
        for (int i = 2; i < POOL_SIZE; i++)
            node_pool[i] = 8'($urandom_range(0, 255));

        // directed table
        // stray events right after reset
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd5,   1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_MFR, CHK_SILENT, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_SECURITY, 8'd5,   1'b0, 1'b0, 1'b0, 4'd15,
                       nis_pkg::STEP_MFR, CHK_SILENT, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(OP_UNUSED,            8'd0,   1'b1, 1'b1, 1'b1, 4'd15,
                       nis_pkg::STEP_PLUS, CHK_SILENT, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        // short non-secure interview on node 0
        add_row(mk_row(nis_pkg::OP_INCLUDED, 8'd0,   1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_MFR, CHK_FIXED, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd0,   1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_VERSION, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd0,   1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_MFR, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd0,   1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_MFR, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd0,   1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_VERSION, CHK_FIXED, nis_pkg::KIND_COMPLETE,
                       nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd0,   1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_VERSION, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        // secure interview on node 255
        add_row(mk_row(nis_pkg::OP_INCLUDED, 8'd255, 1'b1, 1'b1, 1'b1, 4'd0,
                       nis_pkg::STEP_MFR, CHK_SILENT, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd255, 1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_MFR, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_SECURITY, 8'd255, 1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_MFR, CHK_SILENT, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_SECURITY, 8'd255, 1'b0, 1'b0, 1'b0, 4'd15,
                       nis_pkg::STEP_MFR, CHK_FIXED, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_SECURITY, 8'd255, 1'b0, 1'b0, 1'b0, 4'd1,
                       nis_pkg::STEP_MFR, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd255, 1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_MFR, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd255, 1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_VERSION, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd255, 1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_PLUS, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd255, 1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_ENDPOINTS, CHK_MODEL, nis_pkg::KIND_GET,
                       nis_pkg::STEP_MFR));
        // reinclusion of a started session, plus-info only plan
        add_row(mk_row(nis_pkg::OP_INCLUDED, 8'd255, 1'b0, 1'b1, 1'b0, 4'd15,
                       nis_pkg::STEP_PLUS, CHK_FIXED, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd255, 1'b1, 1'b1, 1'b1, 4'd15,
                       nis_pkg::STEP_MFR, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd255, 1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_VERSION, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_REPORT,   8'd255, 1'b0, 1'b0, 1'b0, 4'd0,
                       nis_pkg::STEP_PLUS, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        // reinclusion turning a started session into a waiting secure one
        add_row(mk_row(nis_pkg::OP_INCLUDED, 8'hAA,  1'b1, 1'b0, 1'b0, 4'd15,
                       nis_pkg::STEP_PLUS, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_INCLUDED, 8'hAA,  1'b1, 1'b1, 1'b1, 4'd0,
                       nis_pkg::STEP_MFR, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));
        add_row(mk_row(nis_pkg::OP_SECURITY, 8'hAA,  1'b0, 1'b0, 1'b0, 4'd8,
                       nis_pkg::STEP_MFR, CHK_MODEL, nis_pkg::KIND_GET, nis_pkg::STEP_MFR));

        // reset
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].res, fires);
        hold_until_drained();

        // random traffic, with one full drain halfway through
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                hold_until_drained();
            it = random_event();
            send_beat(it, CHK_MODEL, no_fixed, fires);
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
